// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks on clk, held off while rst is high.
// The enclosing module must have signals named clk and rst.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true on a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- design/cod_pkg.sv -----
package cod_pkg;

  localparam int ENTRY_COUNT = 64;
  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  localparam int KIND_W = 2;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 72;

  localparam logic [8:0] ENTRY_LIMIT = 9'(ENTRY_COUNT);

  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME  = 2'd0,
    KIND_DEFINE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_WRITE  = 2'd3
  } kind_t;

  localparam logic [7:0] MSG_GET   = 8'd0;
  localparam logic [7:0] MSG_SET   = 8'd1;
  localparam logic [7:0] MSG_VALUE = 8'd2;

  localparam logic [7:0] TYPE_S16   = 8'd1;
  localparam logic [7:0] TYPE_FLOAT = 8'd4;

  localparam logic [2:0] SIZE_NONE = 3'd0;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  localparam logic [7:0] RESP_SIZE = 8'd4;
  localparam logic [31:0] HALF_MASK = 32'h0000_ffff;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  frame_type;
    logic [7:0]  frame_size;
    logic [7:0]  entry_index;
    logic [7:0]  obj_type;
    logic [31:0] value_in;
    logic        clear_flag;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  resp_type;
    logic [7:0]  resp_size;
    logic [7:0]  resp_index;
    logic [7:0]  resp_obj_type;
    logic [31:0] resp_value;
    logic        updated;
  } result_t;

  typedef struct packed {
    logic [2:0] vtype;
    logic [2:0] size;
    logic       defined;
    logic       updated;
  } meta_t;

  localparam meta_t META_RESET = '{vtype: 3'd0, size: SIZE_NONE, defined: 1'b0,
                                   updated: 1'b1};

  typedef struct packed {
    logic             meta_we;
    logic             value_we;
    logic [IDX_W-1:0] addr;
    meta_t            meta;
    logic [31:0]      value;
  } wr_t;

  function automatic logic [2:0] size_of_type(input logic [7:0] t);
    logic [2:0] sz;
    if (t <= TYPE_S16) begin
      sz = SIZE_HALF;
    end else if (t <= TYPE_FLOAT) begin
      sz = SIZE_WORD;
    end else begin
      sz = SIZE_NONE;
    end
    return sz;
  endfunction

  function automatic logic [31:0] fit_value(input logic [31:0] v, input logic [2:0] size);
    return (size == SIZE_HALF) ? (v & HALF_MASK) : v;
  endfunction

endpackage

// ----- design/cod_table.sv -----
`include "assert_macros.svh"

module cod_table (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [cod_pkg::IDX_W-1:0] rd_addr,
  input  cod_pkg::wr_t            wr,
  output cod_pkg::meta_t          rd_meta,
  output logic [31:0]             rd_value
);
  import cod_pkg::*;

  meta_t       meta_mem [ENTRY_COUNT];
  logic [31:0] value_mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] valid;

  meta_t       meta_q;
  logic [31:0] value_q;
  logic        valid_q;
  logic        hit_meta_q;
  logic        hit_value_q;
  meta_t       byp_meta_q;
  logic [31:0] byp_value_q;

  always_ff @(posedge clk) begin
    if (wr.meta_we) begin
      meta_mem[wr.addr] <= wr.meta;
    end
    if (wr.value_we) begin
      value_mem[wr.addr] <= wr.value;
    end
    if (rd_en) begin
      meta_q  <= meta_mem[rd_addr];
      value_q <= value_mem[rd_addr];
    end
  end

  // An entry whose marks were never written since reset reads its marks as META_RESET.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.meta_we) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // Forward a write that lands on the same edge as the read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      valid_q     <= valid[rd_addr];
      hit_meta_q  <= wr.meta_we && (wr.addr == rd_addr);
      hit_value_q <= wr.value_we && (wr.addr == rd_addr);
      byp_meta_q  <= wr.meta;
      byp_value_q <= wr.value;
    end
  end

  assign rd_meta  = hit_meta_q ? byp_meta_q : (valid_q ? meta_q : META_RESET);
  assign rd_value = hit_value_q ? byp_value_q : value_q;

  `ASSERT_PROP(a_value_with_meta, wr.value_we |-> wr.meta_we,
               "value written without its entry marks")
  `ASSERT_PROP(a_valid_after_write, wr.meta_we |=> valid[$past(wr.addr)],
               "entry not marked valid after write")

endmodule

// ----- design/cod_exec.sv -----
module cod_exec (
  input  logic             fire,
  input  cod_pkg::item_t   item,
  input  cod_pkg::meta_t   rd_meta,
  input  logic [31:0]      rd_value,
  output cod_pkg::wr_t     wr,
  output cod_pkg::result_t res
);
  import cod_pkg::*;

  logic       in_range;
  logic [2:0] type_size;
  logic       frame_ok;
  logic       value_we;
  meta_t      meta_n;
  logic [31:0] value_n;

  assign in_range  = {1'b0, item.entry_index} < ENTRY_LIMIT;
  assign type_size = size_of_type(item.obj_type);

  assign frame_ok = rd_meta.defined
                 && (item.frame_size == {5'b0, rd_meta.size})
                 && (item.obj_type == {5'b0, rd_meta.vtype})
                 && (item.frame_size == {5'b0, type_size})
                 && ((item.frame_type == MSG_GET) || (item.frame_type == MSG_SET));

  always_comb begin
    res      = '0;
    meta_n   = rd_meta;
    value_n  = rd_value;
    value_we = 1'b0;
    if (in_range) begin
      unique case (item.kind)
        KIND_FRAME: begin
          if (frame_ok) begin
            if (item.frame_type == MSG_SET) begin
              value_n        = fit_value(item.value_in, rd_meta.size);
              value_we       = 1'b1;
              meta_n.updated = 1'b1;
            end
            res.ok            = 1'b1;
            res.resp_type     = MSG_VALUE;
            res.resp_size     = RESP_SIZE;
            res.resp_index    = item.entry_index;
            res.resp_obj_type = item.obj_type;
            res.resp_value    = value_n;
          end
        end
        KIND_DEFINE: begin
          // An invalid type still resizes the entry to zero.
          meta_n.size = type_size;
          if (type_size != SIZE_NONE) begin
            value_n        = fit_value(item.value_in, type_size);
            value_we       = 1'b1;
            meta_n.defined = 1'b1;
            meta_n.vtype   = item.obj_type[2:0];
            meta_n.updated = 1'b1;
            res.ok         = 1'b1;
          end
        end
        KIND_READ: begin
          res.updated = rd_meta.updated;
          if (rd_meta.defined) begin
            if (item.clear_flag) begin
              meta_n.updated = 1'b0;
            end
            res.ok         = 1'b1;
            res.resp_value = rd_value;
          end
        end
        KIND_WRITE: begin
          if (rd_meta.defined) begin
            value_n        = fit_value(item.value_in, rd_meta.size);
            value_we       = 1'b1;
            meta_n.updated = 1'b1;
            res.ok         = 1'b1;
          end
        end
      endcase
    end
  end

  assign wr.meta_we  = fire && in_range;
  assign wr.value_we = fire && in_range && value_we;
  assign wr.addr     = item.entry_index[IDX_W-1:0];
  assign wr.meta     = meta_n;
  assign wr.value    = value_n;

endmodule

// ----- design/can_object_dictionary_responder_top.sv -----
// Object dictionary responder: a table of typed 32-bit entries served by CAN
// get/set frames and by local define, read and write accesses.
// Input channel s_*: one transfer per item. tuser carries the item kind
// (CAN frame, define, local read, local write); tdata carries the frame and
// access fields. Output channel m_*: exactly one result transfer per item, in
// order; tuser carries ok, tdata the response frame fields and the updated flag.
// Throughput: one item per cycle while the receiver does not stall. The table
// read registers together with the item, and the result register loads from the
// read stage when the output register is free. The table write-back happens on
// the edge the result loads, with a forwarding path so back-to-back items on the
// same entry see it.
// Reset clears the per-entry valid bits, so every entry reads as undefined with
// its updated flag set right after reset; no clearing pass.
// When the receiver stalls, the finished result holds in the output register,
// one more item can wait in the read stage, and s_tready then drops until
// the result is taken.
`include "assert_macros.svh"

module can_object_dictionary_responder_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // frame_type, frame_size, entry_index, obj_type, value_in, clear_flag, zero pad
  input  logic [cod_pkg::IN_DATA_W-1:0]   s_tdata,
  // kind
  input  logic [cod_pkg::KIND_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // resp_type, resp_size, resp_index, resp_obj_type, resp_value, updated, zero pad
  output logic [cod_pkg::OUT_DATA_W-1:0]  m_tdata,
  // ok
  output logic [0:0]                      m_tuser
);
  import cod_pkg::*;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    accept;
  logic    out_free;
  logic    s1_fire;
  meta_t   rd_meta;
  logic [31:0] rd_value;
  wr_t     wr;
  result_t res;
  result_t out_res;
  logic    out_valid;

  assign in_item.kind        = kind_t'(s_tuser);
  assign in_item.frame_type  = s_tdata[7:0];
  assign in_item.frame_size  = s_tdata[15:8];
  assign in_item.entry_index = s_tdata[23:16];
  assign in_item.obj_type    = s_tdata[31:24];
  assign in_item.value_in    = s_tdata[63:32];
  assign in_item.clear_flag  = s_tdata[64];

  assign out_free = !out_valid || m_tready;
  assign s1_fire  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

  cod_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (in_item.entry_index[IDX_W-1:0]),
    .wr       (wr),
    .rd_meta  (rd_meta),
    .rd_value (rd_value)
  );

  cod_exec u_exec (
    .fire     (s1_fire),
    .item     (s1_item),
    .rd_meta  (rd_meta),
    .rd_value (rd_value),
    .wr       (wr),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= res;
    end
  end

  assign m_tvalid      = out_valid;
  assign m_tuser       = out_res.ok;
  assign m_tdata[7:0]   = out_res.resp_type;
  assign m_tdata[15:8]  = out_res.resp_size;
  assign m_tdata[23:16] = out_res.resp_index;
  assign m_tdata[31:24] = out_res.resp_obj_type;
  assign m_tdata[63:32] = out_res.resp_value;
  assign m_tdata[64]    = out_res.updated;
  assign m_tdata[OUT_DATA_W-1:65] = '0;

  `ASSERT_NEVER(a_no_accept_when_blocked, s1_valid && !out_free && accept,
                "item accepted while read stage is blocked")
  `ASSERT_PROP(a_fail_fields_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata[63:0] == 64'd0),
               "failed result carries nonzero frame fields")
  `ASSERT_PROP(a_result_follows_item, s1_fire |=> m_tvalid,
               "result register not loaded after read stage")

endmodule

// ----- sim/can_object_dictionary_responder_top_tb.sv -----
`timescale 1ns / 100ps

module can_object_dictionary_responder_top_tb;
  import cod_pkg::*;

  localparam logic [7:0] TYPE_U16 = 8'd0;
  localparam logic [7:0] TYPE_U32 = 8'd2;
  localparam logic [7:0] TYPE_S32 = 8'd3;
  localparam logic [7:0] FRAME_BAD = 8'hff;
  localparam bit ROW_PREDICTED = 1'b0;
  localparam bit ROW_FIXED = 1'b1;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_AT = 250;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    item_t   it;
    bit      fixed;
    result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = KIND_FRAME;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  logic hold_request = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;

  // shadow copy of the dictionary
  logic [31:0] dict_value [ENTRY_COUNT];
  logic [7:0]  dict_type [ENTRY_COUNT];
  logic [2:0]  dict_size [ENTRY_COUNT];
  logic        dict_defined [ENTRY_COUNT];
  logic        dict_updated [ENTRY_COUNT];

  result_t expected_responses [$];
  row_t stimulus_table [$];

  can_object_dictionary_responder_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [2:0] type_bytes(input logic [7:0] t);
    if (t <= TYPE_S16) return SIZE_HALF;
    if (t <= TYPE_FLOAT) return SIZE_WORD;
    return SIZE_NONE;
  endfunction

  function automatic logic [31:0] stored_word(input logic [31:0] v, input logic [2:0] sz);
    return (sz == SIZE_HALF) ? {16'd0, v[15:0]} : v;
  endfunction

  // advance the shadow dictionary by one item and return its response
  function automatic result_t dictionary_response(input item_t it);
    result_t r;
    int unsigned i;
    logic [2:0] sz;
    r = '0;
    i = 32'(it.entry_index);
    if (i >= ENTRY_COUNT) return r;
    case (it.kind)
      KIND_FRAME: begin
        if (!dict_defined[i] || it.frame_size != 8'(dict_size[i]) ||
            it.obj_type != dict_type[i] ||
            it.frame_size != 8'(type_bytes(it.obj_type)))
          return r;
        if (it.frame_type == MSG_SET) begin
          dict_value[i] = stored_word(it.value_in, it.frame_size[2:0]);
          dict_updated[i] = 1'b1;
        end else if (it.frame_type != MSG_GET) begin
          return r;
        end
        r.ok = 1'b1;
        r.resp_type = MSG_VALUE;
        r.resp_size = RESP_SIZE;
        r.resp_index = it.entry_index;
        r.resp_obj_type = it.obj_type;
        r.resp_value = dict_value[i];
      end
      KIND_DEFINE: begin
        sz = type_bytes(it.obj_type);
        dict_size[i] = sz;
        if (sz == SIZE_NONE) return r;
        dict_value[i] = stored_word(it.value_in, sz);
        dict_defined[i] = 1'b1;
        dict_type[i] = it.obj_type;
        dict_updated[i] = 1'b1;
        r.ok = 1'b1;
      end
      KIND_READ: begin
        r.updated = dict_updated[i];
        if (!dict_defined[i]) return r;
        if (it.clear_flag) dict_updated[i] = 1'b0;
        r.ok = 1'b1;
        r.resp_value = dict_value[i];
      end
      default: begin
        if (!dict_defined[i]) return r;
        dict_value[i] = stored_word(it.value_in, dict_size[i]);
        dict_updated[i] = 1'b1;
        r.ok = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic add_row(input kind_t k, input logic [7:0] ftype, fsize, idx, otype,
                         input logic [31:0] value, input logic clr,
                         input bit fixed, input logic want_ok, input logic want_upd);
    row_t r;
    r.it.kind = k;
    r.it.frame_type = ftype;
    r.it.frame_size = fsize;
    r.it.entry_index = idx;
    r.it.obj_type = otype;
    r.it.value_in = value;
    r.it.clear_flag = clr;
    r.fixed = fixed;
    r.want = '0;
    r.want.ok = want_ok;
    r.want.updated = want_upd;
    stimulus_table.push_back(r);
  endtask

  // hold the item until its transfer; returns at the accepting edge
  task automatic offer(input item_t it);
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, it.clear_flag, it.value_in, it.obj_type, it.entry_index,
                it.frame_size, it.frame_type};
    s_tuser <= it.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9) == 0) ? 200 : $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: tdata %h, tuser %h", m_tdata, m_tuser);
      end else begin
        want = expected_responses.pop_front();
        check_field("ok", 32'(want.ok), 32'(m_tuser[0]));
        check_field("resp_type", 32'(want.resp_type), 32'(m_tdata[7:0]));
        check_field("resp_size", 32'(want.resp_size), 32'(m_tdata[15:8]));
        check_field("resp_index", 32'(want.resp_index), 32'(m_tdata[23:16]));
        check_field("resp_obj_type", 32'(want.resp_obj_type), 32'(m_tdata[31:24]));
        check_field("resp_value", want.resp_value, m_tdata[63:32]);
        check_field("updated", 32'(want.updated), 32'(m_tdata[64]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    tick = 0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(3);
        mode_left = $urandom_range(400, 40);
      end
      mode_left--;
      tick++;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(1) == 0);
        2: m_tready <= (tick[1:0] != 2'd3);
        default: m_tready <= ($urandom_range(9) == 0);
      endcase
      @(posedge clk);
    end
  end

  initial begin
    item_t it;
    result_t want;
    int unsigned n;
    int unsigned pick;
    int unsigned slot;
    bit well;
    logic [7:0] last_index;

    for (int i = 0; i < ENTRY_COUNT; i++) begin
      dict_value[i] = '0;
      dict_type[i] = '0;
      dict_size[i] = SIZE_NONE;
      dict_defined[i] = 1'b0;
      dict_updated[i] = 1'b1;
    end

    add_row(KIND_READ, MSG_GET, 8'd0, 8'd0, TYPE_U16, 32'd0, 1'b0, ROW_FIXED, 1'b0, 1'b1);
    add_row(KIND_FRAME, MSG_GET, 8'd2, 8'd0, TYPE_U16, 32'd0, 1'b0, ROW_FIXED, 1'b0, 1'b0);
    add_row(KIND_WRITE, MSG_GET, 8'd0, 8'd0, TYPE_U16, 32'h1, 1'b0, ROW_FIXED, 1'b0, 1'b0);
    add_row(KIND_DEFINE, MSG_GET, 8'd0, 8'd0, TYPE_U16, 32'hdeadbeef, 1'b0,
            ROW_FIXED, 1'b1, 1'b0);
    add_row(KIND_DEFINE, MSG_GET, 8'd0, 8'd63, TYPE_FLOAT, 32'hffffffff, 1'b1,
            ROW_FIXED, 1'b1, 1'b0);
    // out of range index
    add_row(KIND_DEFINE, MSG_GET, 8'd0, 8'd64, TYPE_S32, 32'h5, 1'b0, ROW_FIXED, 1'b0, 1'b0);
    add_row(KIND_READ, MSG_GET, 8'd0, 8'd255, TYPE_U16, 32'd0, 1'b1, ROW_FIXED, 1'b0, 1'b0);
    add_row(KIND_FRAME, MSG_GET, 8'd2, 8'd0, TYPE_U16, 32'd0, 1'b0, ROW_PREDICTED, 1'b0, 1'b0);
    add_row(KIND_FRAME, MSG_SET, 8'd2, 8'd0, TYPE_U16, 32'h12345678, 1'b0,
            ROW_PREDICTED, 1'b0, 1'b0);
    add_row(KIND_FRAME, MSG_SET, 8'd4, 8'd63, TYPE_FLOAT, 32'd0, 1'b0,
            ROW_PREDICTED, 1'b0, 1'b0);
    // value message and unknown frame type get no response
    add_row(KIND_FRAME, MSG_VALUE, 8'd2, 8'd0, TYPE_U16, 32'd0, 1'b0, ROW_FIXED, 1'b0, 1'b0);
    add_row(KIND_FRAME, FRAME_BAD, 8'd2, 8'd0, TYPE_U16, 32'd0, 1'b0, ROW_FIXED, 1'b0, 1'b0);
    // size and type mismatch
    add_row(KIND_FRAME, MSG_GET, 8'd4, 8'd0, TYPE_U16, 32'd0, 1'b0, ROW_FIXED, 1'b0, 1'b0);
    add_row(KIND_FRAME, MSG_GET, 8'd2, 8'd0, TYPE_S16, 32'd0, 1'b0, ROW_FIXED, 1'b0, 1'b0);
    add_row(KIND_READ, MSG_GET, 8'd0, 8'd0, TYPE_U16, 32'd0, 1'b1, ROW_PREDICTED, 1'b0, 1'b0);
    add_row(KIND_READ, MSG_GET, 8'd0, 8'd0, TYPE_U16, 32'd0, 1'b0, ROW_PREDICTED, 1'b0, 1'b0);
    add_row(KIND_WRITE, MSG_GET, 8'd0, 8'd0, TYPE_U16, 32'hffffffff, 1'b0,
            ROW_FIXED, 1'b1, 1'b0);
    add_row(KIND_READ, MSG_GET, 8'd0, 8'd0, TYPE_U16, 32'd0, 1'b1, ROW_PREDICTED, 1'b0, 1'b0);
    // undefined entry: write fails, read still reports the updated mark
    add_row(KIND_WRITE, MSG_GET, 8'd0, 8'd5, TYPE_U16, 32'h7, 1'b0, ROW_FIXED, 1'b0, 1'b0);
    add_row(KIND_READ, MSG_GET, 8'd0, 8'd5, TYPE_U16, 32'd0, 1'b1, ROW_FIXED, 1'b0, 1'b1);
    add_row(KIND_DEFINE, MSG_GET, 8'd0, 8'd1, TYPE_S16, 32'h00008000, 1'b0,
            ROW_FIXED, 1'b1, 1'b0);
    // redefine with invalid type drops the size, keeps the rest
    add_row(KIND_DEFINE, MSG_GET, 8'd0, 8'd1, FRAME_BAD, 32'h1234, 1'b0,
            ROW_FIXED, 1'b0, 1'b0);
    add_row(KIND_FRAME, MSG_GET, 8'd2, 8'd1, TYPE_S16, 32'd0, 1'b0, ROW_FIXED, 1'b0, 1'b0);
    add_row(KIND_READ, MSG_GET, 8'd0, 8'd1, TYPE_U16, 32'd0, 1'b0, ROW_PREDICTED, 1'b0, 1'b0);
    add_row(KIND_DEFINE, MSG_GET, 8'd0, 8'd2, TYPE_U32, 32'h80000000, 1'b0,
            ROW_FIXED, 1'b1, 1'b0);
    add_row(KIND_FRAME, MSG_GET, 8'd4, 8'd2, TYPE_U32, 32'd0, 1'b0, ROW_PREDICTED, 1'b0, 1'b0);
    add_row(KIND_DEFINE, MSG_GET, 8'd0, 8'd3, TYPE_S32, 32'h7fffffff, 1'b0,
            ROW_FIXED, 1'b1, 1'b0);
    add_row(KIND_FRAME, MSG_SET, 8'd4, 8'd3, TYPE_S32, 32'h80000000, 1'b0,
            ROW_PREDICTED, 1'b0, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stimulus_table[r]) begin
      offer(stimulus_table[r].it);
      want = dictionary_response(stimulus_table[r].it);
      if (stimulus_table[r].fixed) want = stimulus_table[r].want;
      expected_responses.push_back(want);
      pace();
    end

    last_index = 8'd0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // long receiver hold-off while items keep coming
      if (n == HOLD_AT) hold_request <= 1'b1;
      pick = $urandom_range(99);
      if (pick < 35) it.kind = KIND_FRAME;
      else if (pick < 55) it.kind = KIND_DEFINE;
      else if (pick < 80) it.kind = KIND_READ;
      else it.kind = KIND_WRITE;
      pick = $urandom_range(99);
      if (pick < 8) it.entry_index = 8'($urandom_range(255, ENTRY_COUNT));
      else if (pick < 30) it.entry_index = last_index;
      else if (pick < 65) it.entry_index = 8'($urandom_range(7));
      else it.entry_index = 8'($urandom_range(ENTRY_COUNT - 1));
      slot = it.entry_index % ENTRY_COUNT;
      well = ($urandom_range(9) < 8);
      it.frame_type = well ? ($urandom_range(1) ? MSG_SET : MSG_GET) : 8'($urandom);
      it.frame_size = well ? 8'(dict_size[slot]) : 8'($urandom);
      if (it.kind == KIND_DEFINE)
        it.obj_type = well ? 8'($urandom_range(4)) : 8'($urandom);
      else
        it.obj_type = well ? dict_type[slot] : 8'($urandom);
      pick = $urandom_range(19);
      if (pick == 0) it.value_in = 32'd0;
      else if (pick == 1) it.value_in = 32'hffffffff;
      else it.value_in = $urandom;
      it.clear_flag = 1'($urandom_range(1));
      offer(it);
      expected_responses.push_back(dictionary_response(it));
      last_index = it.entry_index;
      pace();
    end
    s_tvalid <= 1'b0;

    while (expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
